// ===== rtl/slfp_pkg.sv =====
package slfp_pkg;

    localparam int SENSOR_COUNT_DEF = 21;
    localparam int FIELD_NUM_W      = 5;
    localparam int ACC_W            = 17;
    localparam int VALUE_W          = 16;
    localparam int SKIP_W           = 4;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 5;

    localparam logic [SKIP_W-1:0]      HEADER_SKIP_RST = 4'd5;
    localparam logic [FIELD_NUM_W-1:0] FIELD_LIMIT_RST = 5'd21;
    localparam logic [ACC_W-1:0]       UNIT_CAP        = 17'd3277;
    localparam logic [ACC_W-1:0]       POS_MAX         = 17'd32767;
    localparam logic [ACC_W-1:0]       NEG_MAX         = 17'd32768;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_SKIP = 2'd0,
        REG_FIELD_LIMIT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NODIGIT = 2'd2
    } field_status_t;

    typedef struct packed {
        logic stop;
        logic frac;
        logic past;
        logic digit;
        logic neg;
        logic nonempty;
    } field_flags_t;

    typedef struct packed {
        logic [FIELD_NUM_W-1:0]   sensor_index;
        field_status_t            field_status;
        logic signed [VALUE_W-1:0] value_tenths;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/sensor_line_field_parser_top.sv =====
// Sensor line field parser.
// s_ channel: one character of a receiver log line per word. s_tuser marks
// the first byte of a line, s_tlast the final one. The first header_skip
// bytes of a line are dropped, the rest is split at ';', and each closed
// field (up to min(field_limit, SENSOR_COUNT) per line) yields one m_ word:
// sensor index, status (ok, empty, no digits) and the reading in tenths.
// cfg_ channel: index 0 writes header_skip, index 1 writes field_limit;
// cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high. The per-byte
// update (multiply by ten, add, saturate) sits between the parse state
// registers and the result register, so each result is registered before m_.
// Reset clears the parse state and the output stage and loads the register
// defaults (5 and 21). When m_tready stalls, a two-entry output stage holds
// results; s_tready drops only once both entries are full.
module sensor_line_field_parser_top #(
    parameter int SENSOR_COUNT = slfp_pkg::SENSOR_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] first_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [4:0] sensor_index,
                                                           // [20:5] value_tenths
    output logic [1:0]                          m_tuser,   // [1:0] field_status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [slfp_pkg::SKIP_W-1:0]      header_skip_reg;
    logic [slfp_pkg::FIELD_NUM_W-1:0] field_limit_reg;
    logic                             accept;
    logic                             res_valid;
    slfp_pkg::result_t                res;
    slfp_pkg::result_t                out_res;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_skip_reg <= slfp_pkg::HEADER_SKIP_RST;
            field_limit_reg <= slfp_pkg::FIELD_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                slfp_pkg::REG_HEADER_SKIP: header_skip_reg <= cfg_data[slfp_pkg::SKIP_W-1:0];
                slfp_pkg::REG_FIELD_LIMIT: field_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    slfp_parser #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata),
        .first_byte  (s_tuser),
        .last_byte   (s_tlast),
        .header_skip (header_skip_reg),
        .field_limit (field_limit_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    slfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {3'b000, out_res.value_tenths, out_res.sensor_index};
    assign m_tuser = out_res.field_status;

endmodule

// ===== rtl/slfp_parser.sv =====
module slfp_parser #(
    parameter int SENSOR_COUNT = slfp_pkg::SENSOR_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic [7:0]                         data_byte,
    input  logic                               first_byte,
    input  logic                               last_byte,
    input  logic [slfp_pkg::SKIP_W-1:0]        header_skip,
    input  logic [slfp_pkg::FIELD_NUM_W-1:0]   field_limit,
    output logic                               res_valid,
    output slfp_pkg::result_t                  res
);

    localparam logic [slfp_pkg::FIELD_NUM_W-1:0] SENSOR_LIMIT =
        slfp_pkg::FIELD_NUM_W'(SENSOR_COUNT);

    logic [slfp_pkg::SKIP_W-1:0]      skip_count_reg, skip_count_next;
    logic [slfp_pkg::FIELD_NUM_W-1:0] field_number_reg, field_number_next;
    logic [slfp_pkg::ACC_W-1:0]       accumulator_reg, accumulator_next;
    slfp_pkg::field_flags_t           field_flags_reg, field_flags_next;

    logic [slfp_pkg::SKIP_W-1:0]      skip_c;
    logic [slfp_pkg::FIELD_NUM_W-1:0] fnum_c;
    logic [slfp_pkg::ACC_W-1:0]       acc_c;
    slfp_pkg::field_flags_t           flags_c;
    logic [slfp_pkg::FIELD_NUM_W-1:0] limit;
    logic [slfp_pkg::ACC_W-1:0]       acc_x10;
    logic [slfp_pkg::ACC_W-1:0]       int_sum;
    logic [slfp_pkg::ACC_W-1:0]       digit_val;
    logic [slfp_pkg::ACC_W-1:0]       mag;
    logic [slfp_pkg::ACC_W-1:0]       mag_sat;
    logic                             is_digit;
    logic                             is_point;
    logic                             is_sign;
    logic                             in_field;
    logic                             close;

    always_comb begin
        skip_c  = first_byte ? '0 : skip_count_reg;
        fnum_c  = first_byte ? '0 : field_number_reg;
        acc_c   = first_byte ? '0 : accumulator_reg;
        flags_c = first_byte ? '0 : field_flags_reg;

        limit     = (field_limit < SENSOR_LIMIT) ? field_limit : SENSOR_LIMIT;
        acc_x10   = slfp_pkg::ACC_W'(acc_c * 17'd10);
        digit_val = slfp_pkg::ACC_W'(data_byte - slfp_pkg::CH_ZERO);
        int_sum   = acc_x10 + digit_val;
        is_digit  = (data_byte >= slfp_pkg::CH_ZERO) && (data_byte <= slfp_pkg::CH_NINE);
        is_point  = (data_byte == slfp_pkg::CH_DOT) || (data_byte == slfp_pkg::CH_COMMA);
        is_sign   = (data_byte == slfp_pkg::CH_PLUS) || (data_byte == slfp_pkg::CH_MINUS);
        in_field  = (skip_c >= header_skip) && (fnum_c < limit);
        close     = in_field && (data_byte == slfp_pkg::CH_SEMI);

        mag = flags_c.frac ? acc_c : acc_x10;
        if (flags_c.neg) begin
            mag_sat = (mag > slfp_pkg::NEG_MAX) ? slfp_pkg::NEG_MAX : mag;
        end else begin
            mag_sat = (mag > slfp_pkg::POS_MAX) ? slfp_pkg::POS_MAX : mag;
        end

        res.sensor_index = fnum_c;
        res.value_tenths = '0;
        if (!flags_c.nonempty) begin
            res.field_status = slfp_pkg::ST_EMPTY;
        end else if (!flags_c.digit) begin
            res.field_status = slfp_pkg::ST_NODIGIT;
        end else begin
            res.field_status = slfp_pkg::ST_OK;
            res.value_tenths = flags_c.neg ? slfp_pkg::VALUE_W'(17'd0 - mag_sat)
                                           : slfp_pkg::VALUE_W'(mag_sat);
        end
        res_valid = accept && close;
    end

    always_comb begin
        skip_count_next   = skip_c;
        field_number_next = fnum_c;
        accumulator_next  = acc_c;
        field_flags_next  = flags_c;

        if (skip_c < header_skip) begin
            skip_count_next = skip_c + 1'b1;
        end else if (close) begin
            field_number_next = fnum_c + 1'b1;
            accumulator_next  = '0;
            field_flags_next  = '0;
        end else if (in_field) begin
            field_flags_next.nonempty = 1'b1;
            if (!flags_c.stop) begin
                if (slfp_pkg::is_space(data_byte)) begin
                    if (flags_c.past) field_flags_next.stop = 1'b1;
                end else if (is_sign) begin
                    if (flags_c.past) begin
                        field_flags_next.stop = 1'b1;
                    end else begin
                        field_flags_next.past = 1'b1;
                        field_flags_next.neg  = (data_byte == slfp_pkg::CH_MINUS);
                    end
                end else if (is_digit) begin
                    field_flags_next.past  = 1'b1;
                    field_flags_next.digit = 1'b1;
                    if (flags_c.frac) begin
                        accumulator_next      = acc_c + digit_val;
                        field_flags_next.stop = 1'b1;
                    end else begin
                        accumulator_next = (int_sum > slfp_pkg::UNIT_CAP) ?
                                           slfp_pkg::UNIT_CAP : int_sum;
                    end
                end else if (is_point) begin
                    if (flags_c.frac) begin
                        field_flags_next.stop = 1'b1;
                    end else begin
                        field_flags_next.past = 1'b1;
                        field_flags_next.frac = 1'b1;
                        accumulator_next      = acc_x10;
                    end
                end else begin
                    field_flags_next.stop = 1'b1;
                end
            end
        end

        if (last_byte) begin
            skip_count_next   = '0;
            field_number_next = '0;
            accumulator_next  = '0;
            field_flags_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg   <= '0;
            field_number_reg <= '0;
            accumulator_reg  <= '0;
            field_flags_reg  <= '0;
        end else if (accept) begin
            skip_count_reg   <= skip_count_next;
            field_number_reg <= field_number_next;
            accumulator_reg  <= accumulator_next;
            field_flags_reg  <= field_flags_next;
        end
    end

endmodule

// ===== rtl/slfp_out_buf.sv =====
module slfp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  slfp_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output slfp_pkg::result_t out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    slfp_pkg::result_t main_data_reg;
    slfp_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) main_data_reg <= skid_data_reg;
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/slfp_checker.sv =====
module slfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == slfp_pkg::ST_OK) || (m_tuser == slfp_pkg::ST_EMPTY) ||
                     (m_tuser == slfp_pkg::ST_NODIGIT))
        else $error("undefined field status");

    a_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != slfp_pkg::ST_OK) |-> m_tdata[20:5] == 16'd0)
        else $error("value on a field without reading");

endmodule

bind sensor_line_field_parser_top slfp_checker u_slfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sensor_line_field_parser_checker.sv =====
module sensor_line_field_parser_checker
    import slfp_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [23:0]            m_tdata,
    input  logic [1:0]             m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            mismatch_count,
    output int unsigned            readings_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SKIP_W-1:0]      cfg_skip = HEADER_SKIP_RST;
    logic [FIELD_NUM_W-1:0] cfg_limit = FIELD_LIMIT_RST;
    logic [SKIP_W-1:0]      hdr_seen = '0;
    logic [FIELD_NUM_W-1:0] field_idx = '0;
    logic [ACC_W-1:0]       magnitude = '0;
    field_flags_t           flags = '0;
    result_t                readings_q[$];
    int unsigned            fail_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic clear_line_state();
        hdr_seen  = '0;
        field_idx = '0;
        magnitude = '0;
        flags     = '0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        int unsigned next;
        next = magnitude;
        flags.nonempty = 1'b1;
        if (!flags.stop) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (flags.past)
                    flags.stop = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                if (flags.past) begin
                    flags.stop = 1'b1;
                end else begin
                    flags.past = 1'b1;
                    if (c == CH_MINUS)
                        flags.neg = 1'b1;
                end
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                flags.past  = 1'b1;
                flags.digit = 1'b1;
                if (flags.frac) begin
                    next = next + (c - CH_ZERO);
                    flags.stop = 1'b1;
                end else begin
                    next = next * 10 + (c - CH_ZERO);
                    if (next > UNIT_CAP)
                        next = UNIT_CAP;
                end
            end else if (c == CH_COMMA || c == CH_DOT) begin
                if (flags.frac) begin
                    flags.stop = 1'b1;
                end else begin
                    flags.past = 1'b1;
                    flags.frac = 1'b1;
                    next = next * 10;
                end
            end else begin
                flags.stop = 1'b1;
            end
            magnitude = next[ACC_W-1:0];
        end
    endtask

    function automatic result_t close_reading();
        result_t     r;
        int unsigned mag;
        r.sensor_index = field_idx;
        r.value_tenths = '0;
        if (!flags.nonempty) begin
            r.field_status = ST_EMPTY;
        end else if (!flags.digit) begin
            r.field_status = ST_NODIGIT;
        end else begin
            r.field_status = ST_OK;
            mag = magnitude;
            if (!flags.frac)
                mag = mag * 10;
            if (flags.neg) begin
                if (mag > NEG_MAX)
                    mag = NEG_MAX;
                r.value_tenths = VALUE_W'(0 - mag);
            end else begin
                if (mag > POS_MAX)
                    mag = POS_MAX;
                r.value_tenths = VALUE_W'(mag);
            end
        end
        return r;
    endfunction

    task automatic step_char(input logic [7:0] c, input logic first, input logic last);
        int unsigned lim;
        lim = (cfg_limit < SENSOR_COUNT) ? cfg_limit : SENSOR_COUNT;
        if (first)
            clear_line_state();
        if (hdr_seen < cfg_skip) begin
            hdr_seen = hdr_seen + 1'b1;
        end else if (field_idx < lim) begin
            if (c == CH_SEMI) begin
                readings_q = {readings_q, close_reading()};
                field_idx = field_idx + 1'b1;
                magnitude = '0;
                flags     = '0;
            end else begin
                absorb_char(c);
            end
        end
        if (last)
            clear_line_state();
    endtask

    task automatic check_reading();
        result_t                   want;
        logic [FIELD_NUM_W-1:0]    got_idx;
        logic signed [VALUE_W-1:0] got_val;
        got_idx = m_tdata[FIELD_NUM_W-1:0];
        got_val = m_tdata[FIELD_NUM_W +: VALUE_W];
        if (readings_q.size() == 0) begin
            report_mismatch("unexpected word, sensor_index", got_idx, -1);
            return;
        end
        want = readings_q.pop_front();
        if (got_idx != want.sensor_index)
            report_mismatch("sensor_index", got_idx, want.sensor_index);
        if (m_tuser != want.field_status)
            report_mismatch("field_status", m_tuser, want.field_status);
        if (got_val != want.value_tenths)
            report_mismatch("value_tenths", got_val, want.value_tenths);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_skip  = HEADER_SKIP_RST;
            cfg_limit = FIELD_LIMIT_RST;
            clear_line_state();
            readings_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_HEADER_SKIP: cfg_skip = cfg_data[SKIP_W-1:0];
                    REG_FIELD_LIMIT: cfg_limit = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                step_char(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                check_reading();
        end
        mismatch_count <= fail_count;
        readings_due   <= readings_q.size();
    end

endmodule

// ===== tb/tb_sensor_line_field_parser_top.sv =====
module tb_sensor_line_field_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slfp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_WORDS    = 190;

    typedef struct packed {
        logic       last;
        logic       first;
        logic [7:0] data;
    } char_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int unsigned mismatch_count;
    int unsigned readings_due;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        hold_req = 1'b0;
    int unsigned quiet_cycles = 0;

    logic [SKIP_W-1:0]      hs_now = HEADER_SKIP_RST;
    logic [FIELD_NUM_W-1:0] fl_now = FIELD_LIMIT_RST;

    char_word_t line_buf[$];
    char_word_t word_q[$];

    sensor_line_field_parser_top #(
        .SENSOR_COUNT(SENSOR_COUNT_DEF)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sensor_line_field_parser_checker #(
        .SENSOR_COUNT(SENSOR_COUNT_DEF)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .readings_due   (readings_due)
    );

    always #5ns aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                        (cfg_valid && cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold off the result side for a long stretch on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_non_semi();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_SEMI);
        return c;
    endfunction

    task automatic push_word(input logic [7:0] c);
        char_word_t w;
        w = '0;
        w.data = c;
        line_buf = {line_buf, w};
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_word(s[i]);
    endtask

    task automatic flush_line(input bit mark_first, input bit mark_last);
        char_word_t w;
        w = line_buf[0];
        w.first = mark_first;
        line_buf[0] = w;
        w = line_buf[line_buf.size() - 1];
        w.last = mark_last;
        line_buf[line_buf.size() - 1] = w;
        foreach (line_buf[i])
            word_q = {word_q, line_buf[i]};
        line_buf.delete();
    endtask

    task automatic build_field();
        int unsigned kind;
        int unsigned n_int;
        kind = $urandom_range(9);
        if (kind == 1) begin
            repeat ($urandom_range(1, 3)) push_word(rand_non_semi());
        end else if (kind != 0) begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2))
                    push_word($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
            case ($urandom_range(3))
                0: push_word(CH_PLUS);
                1: push_word(CH_MINUS);
                default: ;
            endcase
            n_int = ($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(3);
            repeat (n_int) push_word(rand_digit());
            if ($urandom_range(1)) begin
                push_word($urandom_range(1) ? CH_DOT : CH_COMMA);
                repeat ($urandom_range(3)) push_word(rand_digit());
            end
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0: push_word(CH_SPACE);
                    1: push_word(CH_MINUS);
                    2: push_word(CH_PLUS);
                    3: push_word(CH_DOT);
                    4: push_word(CH_COMMA);
                    default: push_word(rand_non_semi());
                endcase
                push_word(rand_digit());
            end
        end
        push_word(CH_SEMI);
    endtask

    task automatic build_line();
        int unsigned n_hdr;
        int unsigned n_fields;
        int unsigned lim;
        lim = (fl_now < SENSOR_COUNT_DEF) ? fl_now : SENSOR_COUNT_DEF;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) push_word(8'($urandom_range(255)));
            flush_line($urandom_range(1) == 1, $urandom_range(1) == 1);
            return;
        end
        n_hdr = ($urandom_range(6) == 0) ? $urandom_range(16) : hs_now;
        repeat (n_hdr) push_word(8'($urandom_range(255)));
        n_fields = ($urandom_range(3) == 0) ? $urandom_range(lim + 2) : $urandom_range(4);
        repeat (n_fields) build_field();
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) push_word(rand_digit());
        if (line_buf.size() == 0)
            push_word(rand_digit());
        flush_line($urandom_range(6) != 0, $urandom_range(6) != 0);
    endtask

    task automatic send_all();
        char_word_t w;
        while (word_q.size() > 0) begin
            w = word_q.pop_front();
            if ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while ($urandom_range(99) < idle_pct) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w.data;
            s_tuser  <= w.first;
            s_tlast  <= w.last;
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic wait_quiet();
        @(posedge aclk);
        while (readings_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [SKIP_W-1:0] skip, input logic [FIELD_NUM_W-1:0] limit,
                             input int unsigned s_idle, input int unsigned r_stall,
                             input bit with_hold);
        wait_quiet();
        write_reg(REG_HEADER_SKIP, CFG_DATA_W'(skip));
        write_reg(REG_FIELD_LIMIT, limit);
        cfg_valid <= 1'b0;
        hs_now    = skip;
        fl_now    = limit;
        idle_pct  = s_idle;
        stall_pct = r_stall;
        while (word_q.size() < PHASE_WORDS) build_line();
        if (with_hold)
            hold_req = 1'b1;
        send_all();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // header with byte extremes, then saturation, both points, empty,
        // no digits, second point, late sign, unterminated tail
        push_word(8'hFF);
        push_word(8'h00);
        push_text("$W1");
        push_text("-3277.9;+12,34;;\te;1..;7-;5");
        flush_line(1'b1, 1'b1);
        send_all();

        run_phase(4'd0, 5'd31, 0, 0, 1'b0);
        run_phase(4'd15, 5'd1, 73, 0, 1'b0);
        run_phase(4'd3, 5'd21, 0, 73, 1'b0);
        run_phase(4'd7, 5'd2, 30, 30, 1'b0);
        run_phase(4'd0, 5'd12, 0, 0, 1'b1);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && readings_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/slfp_pkg.sv
rtl/slfp_parser.sv
rtl/slfp_out_buf.sv
rtl/sensor_line_field_parser_top.sv
rtl/slfp_checker.sv
tb/sensor_line_field_parser_checker.sv
tb/tb_sensor_line_field_parser_top.sv
